// ===== src/lmfr_pkg.sv =====
// Shared types and codes for the LED matrix frame rotate unit.
// No dependencies; imported by every module of the block.
package lmfr_pkg;

   // Input item kinds
   localparam logic [2:0] KIND_DRAW = 3'd0;
   localparam logic [2:0] KIND_FILL = 3'd1;
   localparam logic [2:0] KIND_ROW  = 3'd2;
   localparam logic [2:0] KIND_EMIT = 3'd3;
   localparam logic [2:0] KIND_RAW  = 3'd4;

   // Commands passed from the front end to the back end
   localparam logic [2:0] OP_DRAW = 3'd0;
   localparam logic [2:0] OP_FILL = 3'd1;
   localparam logic [2:0] OP_ROW  = 3'd2;
   localparam logic [2:0] OP_EMIT = 3'd3;
   localparam logic [2:0] OP_RAW  = 3'd4;

   // Rotation register codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Register index of the rotation register
   localparam logic REG_ROTATION = 1'b0;

   localparam int unsigned NUM_ROWS = 8;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] col_x;
      logic [3:0] row_y;
      logic       pixel_on;
      logic [7:0] row_data;
   } req_type;

   typedef struct packed {
      logic [2:0] row_index;
      logic [7:0] row_byte;
      logic       is_remapped;
      logic       last_row;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] row;
      logic [2:0] col;
      logic       pixel_on;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[i];
      end
      return r;
   endfunction

   function automatic logic [7:0] rotr1(input logic [7:0] v);
      return {v[0], v[7:1]};
   endfunction

   function automatic logic [7:0] rotl1(input logic [7:0] v);
      return {v[6:0], v[7]};
   endfunction

endpackage

// ===== src/lmfr_front.sv =====
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on lmfr_pkg.
module lmfr_front
   import lmfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    cmd_in;
   logic       keep;
   logic       accept;
   logic       wr;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Classify; drop unused kinds and out-of-range coordinates here
   always_comb begin
      cmd_in.row      = req_data.row_y[2:0];
      cmd_in.col      = req_data.col_x[2:0];
      cmd_in.pixel_on = req_data.pixel_on;
      cmd_in.data     = req_data.row_data;
      cmd_in.op       = OP_DRAW;
      keep            = 1'b0;
      case (req_data.kind)
         KIND_DRAW: begin
            cmd_in.op = OP_DRAW;
            keep      = !req_data.col_x[3] && !req_data.row_y[3];
         end
         KIND_FILL: begin
            cmd_in.op = OP_FILL;
            keep      = 1'b1;
         end
         KIND_ROW: begin
            cmd_in.op = OP_ROW;
            keep      = !req_data.row_y[3];
         end
         KIND_EMIT: begin
            cmd_in.op = OP_EMIT;
            keep      = 1'b1;
         end
         KIND_RAW: begin
            cmd_in.op = OP_RAW;
            keep      = 1'b1;
         end
         default: begin
            cmd_in.op = OP_DRAW;
            keep      = 1'b0;
         end
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign accept    = push && !full;
   assign wr        = accept && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!wr && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== src/lmfr_back.sv =====
// Back end: holds the 8x8 frame, applies write commands and sequences readbacks.
// Depends on lmfr_pkg.
module lmfr_back
   import lmfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] rotation,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   logic [7:0] frame_ff [NUM_ROWS];
   logic [7:0] frame_in [NUM_ROWS];
   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       remap_ff, remap_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic       emit;
   logic [2:0] col_sel;
   logic [2:0] row_addr;
   logic [7:0] sel_row;
   logic [7:0] gath_desc;
   logic [7:0] gath_asc;
   logic [7:0] remap_byte;
   logic [7:0] row_val;

   assign cmd_pop  = cmd_valid && !busy_ff;
   assign emit     = busy_ff && (!out_valid_ff || pop);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   // Remap of output row cnt_ff
   always_comb begin
      col_sel  = 3'd7 - cnt_ff;
      row_addr = (rotation == ROT_90) ? (3'd7 - cnt_ff) : cnt_ff;
      sel_row  = frame_ff[row_addr];
      for (int j = 0; j < NUM_ROWS; j++) begin
         gath_desc[3'(7 - j)] = frame_ff[j][col_sel];
         gath_asc[j]          = frame_ff[j][col_sel];
      end
      case (rotation)
         ROT_0:   remap_byte = rotr1(gath_desc);
         ROT_90:  remap_byte = rotr1(sel_row);
         ROT_180: remap_byte = rotr1(gath_asc);
         default: remap_byte = reverse8(rotl1(sel_row));
      endcase
      row_val = remap_ff ? remap_byte : frame_ff[cnt_ff];
   end

   // Frame updates
   always_comb begin
      frame_in = frame_ff;
      if (cmd_pop) begin
         case (cmd.op)
            OP_DRAW: frame_in[cmd.row][3'd7 - cmd.col] = cmd.pixel_on;
            OP_FILL: begin
               for (int k = 0; k < NUM_ROWS; k++) begin
                  frame_in[k] = {8{cmd.pixel_on}};
               end
            end
            OP_ROW:  frame_in[cmd.row] = cmd.data;
            default: frame_in = frame_ff;
         endcase
      end
   end

   // Readback sequencer and output register
   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      remap_in     = remap_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (cmd_pop && (cmd.op == OP_EMIT || cmd.op == OP_RAW)) begin
         busy_in  = 1'b1;
         cnt_in   = 3'd0;
         remap_in = (cmd.op == OP_EMIT);
      end else if (emit) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
      if (emit) begin
         out_valid_in       = 1'b1;
         out_in.row_index   = cnt_ff;
         out_in.row_byte    = row_val;
         out_in.is_remapped = remap_ff;
         out_in.last_row    = (cnt_ff == 3'd7);
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ROWS; k++) begin
            frame_ff[k] <= 8'h00;
         end
         busy_ff      <= 1'b0;
         cnt_ff       <= 3'd0;
         remap_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         remap_ff     <= remap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ===== src/led_matrix_frame_rotate_unit.sv =====
// Top level of the LED matrix frame rotate unit: CSR port, front end and back end.
// Depends on lmfr_pkg, lmfr_front and lmfr_back.
//
//   Channel    Direction  Handshake              Payload
//   request    in         push / full            req_data (req_type)
//   response   out        pop / empty            rsp_data (rsp_type)
//   csr        in/out     psel/penable/pready    paddr, pwdata, prdata
//
// Write items (draw, fill, row write) are applied to the frame as the back end pops them.
// A readback is started by its command, then yields one row per cycle while the output
// register has room, eight rows in all, counted by the row counter of the back-end sequencer.
// A two-entry command queue lets the front end keep accepting while the back
// end is busy; a full output register stalls the sequencer in place.
// Reset clears the frame, the rotation register and all queues.
module led_matrix_frame_rotate_unit
   import lmfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0] rot_ff, rot_in;
   logic       csr_write;
   logic       cmd_valid;
   logic       cmd_pop;
   cmd_type    cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      rot_in = rot_ff;
      if (csr_write && (paddr[2] == REG_ROTATION)) begin
         rot_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff <= ROT_0;
      end else begin
         rot_ff <= rot_in;
      end
   end

   assign prdata = (paddr[2] == REG_ROTATION) ? {30'd0, rot_ff} : 32'd0;

   lmfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   lmfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rotation  (rot_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for led_matrix_frame_rotate_unit: drives frame commands and
// rotation writes, predicts every readback row and compares it on the response queue.
// Depends on lmfr_pkg and the RTL of the block.
module tb_top
   import lmfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_ROTATION = 3'(4 * REG_ROTATION);
   localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
   localparam int         DRAIN_CYCLES  = 24;
   localparam int         LONG_HOLD     = 300;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         PHASE_ITEMS   = 42;
   localparam int         REPORT_LIMIT  = 10;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        push    = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop     = 1'b0;
   rsp_type     rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow of the block's frame and rotation register
   logic [7:0]  frame_model [NUM_ROWS] = '{default: '0};
   logic [1:0]  rotation_model = ROT_0;

   req_type     cmd_backlog [$];
   rsp_type     rows_due [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          gap_cnt = 0;
   int          stall_cnt = 0;
   int          hold_asks = 0;
   int          holds_done = 0;
   bit          calm = 1'b0;

   led_matrix_frame_rotate_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] display_byte(int k);
      logic [7:0] g;
      logic [7:0] v;
      g = '0;
      v = '0;
      case (rotation_model)
         ROT_0: begin
            for (int j = 0; j < 8; j++) g[7 - j] = frame_model[j][7 - k];
            v = {g[0], g[7:1]};
         end
         ROT_90: begin
            g = frame_model[7 - k];
            v = {g[0], g[7:1]};
         end
         ROT_180: begin
            for (int j = 0; j < 8; j++) g[j] = frame_model[j][7 - k];
            v = {g[0], g[7:1]};
         end
         default: begin
            g = {frame_model[k][6:0], frame_model[k][7]};
            for (int j = 0; j < 8; j++) v[j] = g[7 - j];
         end
      endcase
      return v;
   endfunction

   // Apply one accepted command to the shadow frame and queue the rows it yields.
   function automatic void apply_frame_cmd(req_type it);
      rsp_type r;
      case (it.kind)
         KIND_DRAW: begin
            if (!it.col_x[3] && !it.row_y[3])
               frame_model[it.row_y[2:0]][7 - it.col_x[2:0]] = it.pixel_on;
         end
         KIND_FILL: begin
            for (int k = 0; k < 8; k++) frame_model[k] = {8{it.pixel_on}};
         end
         KIND_ROW: begin
            if (!it.row_y[3]) frame_model[it.row_y[2:0]] = it.row_data;
         end
         KIND_EMIT, KIND_RAW: begin
            for (int k = 0; k < 8; k++) begin
               r.row_index   = 3'(k);
               r.row_byte    = (it.kind == KIND_EMIT) ? display_byte(k) : frame_model[k];
               r.is_remapped = (it.kind == KIND_EMIT);
               r.last_row    = (k == 7);
               rows_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_type frame_cmd(logic [2:0] kind, logic [3:0] x, logic [3:0] y,
                                         logic on, logic [7:0] data);
      req_type it;
      it.kind     = kind;
      it.col_x    = x;
      it.row_y    = y;
      it.pixel_on = on;
      it.row_data = data;
      return it;
   endfunction

   // Mostly in-range draws and row writes with readbacks mixed in; a little noise.
   function automatic req_type random_cmd();
      req_type it;
      int      pick;
      pick        = $urandom_range(0, 99);
      it.col_x    = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(0, 7));
      it.row_y    = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(0, 7));
      it.pixel_on = 1'($urandom());
      it.row_data = 8'($urandom());
      if (pick < 35)      it.kind = KIND_DRAW;
      else if (pick < 42) it.kind = KIND_FILL;
      else if (pick < 66) it.kind = KIND_ROW;
      else if (pick < 82) it.kind = KIND_EMIT;
      else if (pick < 95) it.kind = KIND_RAW;
      else                it.kind = 3'($urandom_range(KIND_RAW + 1, 7));
      return it;
   endfunction

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_ROTATION) rotation_model = data[1:0];
   endtask

   task automatic settle();
      while (cmd_backlog.size() != 0 || push || rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: offer the oldest pending command, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         push    <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (push && !full) begin
            apply_frame_cmd(req_data);
            void'(cmd_backlog.pop_front());
         end
         if (push && full) begin
            // hold the offered transaction until it is taken
         end else if (gap_cnt > 0) begin
            gap_cnt--;
            push <= 1'b0;
         end else if (!calm && cmd_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
            gap_cnt = $urandom_range(0, 16);
            push <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            push     <= 1'b1;
            req_data <= cmd_backlog[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: check each row transaction against the oldest expected row
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (pop && !empty) begin
            if (rows_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected row: index %0d byte %02h remap %0b last %0b",
                           rsp_data.row_index, rsp_data.row_byte,
                           rsp_data.is_remapped, rsp_data.last_row);
            end else begin
               want = rows_due.pop_front();
               if (rsp_data.row_index !== want.row_index || rsp_data.row_byte !== want.row_byte
                   || rsp_data.is_remapped !== want.is_remapped
                   || rsp_data.last_row !== want.last_row) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("row mismatch: expected index %0d byte %02h remap %0b last %0b, %s",
                              want.row_index, want.row_byte, want.is_remapped, want.last_row,
                              $sformatf("got index %0d byte %02h remap %0b last %0b",
                                        rsp_data.row_index, rsp_data.row_byte,
                                        rsp_data.is_remapped, rsp_data.last_row));
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            pop <= 1'b0;
         end else if (hold_asks != holds_done) begin
            holds_done++;
            stall_cnt = LONG_HOLD - 1;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 16);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [1:0]  rot_plan [7];
      logic [31:0] value;
      rot_plan = '{ROT_90, ROT_180, ROT_270, ROT_0, ROT_270, ROT_90, ROT_180};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, out-of-range coordinates, unused kinds, fills
      cmd_backlog.push_back(frame_cmd(KIND_RAW, 4'($urandom()), 4'($urandom()), 1'b1, 8'hFF));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd0, 4'd0, 1'b1, 8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd7, 4'd7, 1'b1, 8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd8, 4'd2, 1'b1, 8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd2, 4'd15, 1'b1, 8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd15, 4'd15, 1'b1, 8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_RAW, 4'd15, 4'd15, 1'b0, 8'h00));
      cmd_backlog.push_back(frame_cmd(KIND_EMIT, 4'($urandom()), 4'($urandom()), 1'b0, 8'h00));
      cmd_backlog.push_back(frame_cmd(KIND_ROW, 4'($urandom()), 4'd3, 1'b0, 8'hA5));
      cmd_backlog.push_back(frame_cmd(KIND_ROW, 4'($urandom()), 4'd8, 1'b1, 8'hFF));
      cmd_backlog.push_back(frame_cmd(KIND_ROW, 4'($urandom()), 4'd15, 1'b1, 8'h5A));
      cmd_backlog.push_back(frame_cmd(KIND_DRAW, 4'd0, 4'd0, 1'b0, 8'hFF));
      for (int k = KIND_RAW + 1; k < 8; k++)
         cmd_backlog.push_back(frame_cmd(3'(k), 4'($urandom()), 4'($urandom()), 1'($urandom()),
                                         8'($urandom())));
      cmd_backlog.push_back(frame_cmd(KIND_EMIT, 4'd0, 4'd0, 1'b1, 8'hFF));
      cmd_backlog.push_back(frame_cmd(KIND_FILL, 4'($urandom()), 4'($urandom()), 1'b1, 8'h00));
      cmd_backlog.push_back(frame_cmd(KIND_RAW, 4'd0, 4'd0, 1'b0, 8'h00));
      cmd_backlog.push_back(frame_cmd(KIND_EMIT, 4'd0, 4'd0, 1'b0, 8'h00));
      cmd_backlog.push_back(frame_cmd(KIND_FILL, 4'($urandom()), 4'($urandom()), 1'b0, 8'hFF));
      cmd_backlog.push_back(frame_cmd(KIND_ROW, 4'd0, 4'd0, 1'b0, 8'h01));
      cmd_backlog.push_back(frame_cmd(KIND_ROW, 4'd0, 4'd7, 1'b0, 8'h80));
      cmd_backlog.push_back(frame_cmd(KIND_EMIT, 4'd0, 4'd0, 1'b0, 8'h00));
      settle();

      // a write to an unmapped index must leave the rotation alone
      value = $urandom();
      value[1:0] = ROT_270;
      csr_write(ADDR_UNMAPPED, value);

      for (int p = 0; p < 7; p++) begin
         if (p != 0) begin
            value = $urandom();
            value[1:0] = rot_plan[p];
            csr_write(ADDR_ROTATION, value);
         end else begin
            csr_write(ADDR_ROTATION, {30'h3FFFFFFF, rot_plan[p]});
         end
         if (p == 2) hold_asks++;
         if (p == 6) calm = 1'b1;
         cmd_backlog.push_back(frame_cmd(KIND_EMIT, 4'($urandom()), 4'($urandom()),
                                         1'($urandom()), 8'($urandom())));
         for (int n = 0; n < PHASE_ITEMS; n++) cmd_backlog.push_back(random_cmd());
         settle();
      end

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
